// File: design/hsl_pkg.sv
// Package: shared constants and types for the HSL lightness gain pixel core.
package hsl_pkg;
	localparam int FracBits = 16;
	localparam int FxW = FracBits + 2;
	localparam logic [FxW-1:0] FxOne = FxW'(1) << FracBits;

	// Reciprocal of an 8-bit divisor, scaled by 2^(FracBits+10).
	// It feeds a first estimate of a quotient, which is then corrected exactly.
	localparam int RecW = FracBits + 11;
	localparam int RecN = 256;

	typedef logic [7:0] chan_t;
	typedef logic [RecN-1:0][RecW-1:0] rec_tab_t;

	typedef struct packed {
		logic [FxW-1:0] lum;
		logic [FxW-1:0] sat;
		logic [2:0]     sector;
		logic [FxW-1:0] frac;
		logic           grey;
	} hsl_t;

	// elaboration only: rounded-up reciprocal of a constant divisor
	function automatic logic [RecW-1:0] recip(input logic [8:0] den);
		logic [RecW-1:0] r;
		r = '0;
		if (den != 9'd0) r = RecW'(((64'd1 << (FracBits + 10)) + 64'(den) - 64'd1) / 64'(den));
		return r;
	endfunction

	function automatic rec_tab_t make_rec_tab();
		rec_tab_t tab;
		for (int i = 0; i < RecN; i++) tab[i] = recip(9'(i));
		return tab;
	endfunction

	// reciprocal table for divisors 0..255, plus the one wide divisor (510)
	localparam rec_tab_t RecTab = make_rec_tab();
	localparam logic [RecW-1:0] Rec510 = recip(9'd510);
endpackage

// File: design/hsl_lightness_gain_pixel_core.sv
// Top level: HSL lightness gain pixel core with pipeline control and output register.
// Pipeline order: forward path stages, reverse path stages, then the output register.
// Throughput: one item per cycle; whole pipeline advances together,
// stalled only when the output register is full and stalled downstream.
// Reset: arst_n clears all valid bits and the gain register (to 0);
// data registers are not reset.
module hsl_lightness_gain_pixel_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  hsl_pkg::chan_t        red_in,
	input  hsl_pkg::chan_t        green_in,
	input  hsl_pkg::chan_t        blue_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hsl_pkg::chan_t        red_out,
	output hsl_pkg::chan_t        green_out,
	output hsl_pkg::chan_t        blue_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic signed [8:0]     cfg_data
);
	import hsl_pkg::*;
	localparam int Depth = 5;
	logic [Depth-1:0] vld_q;
	logic en;
	logic signed [8:0] gain_q;
	hsl_t hsl;
	chan_t r, g, b;

	// pipeline moves whenever the output register can take its item
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
			gain_q <= '0;
		end else begin
			if (cfg_valid) gain_q <= cfg_data;
			if (en) begin
				vld_q <= {vld_q[Depth-2:0], in_valid};
				out_valid <= vld_q[Depth-1];
			end
		end
	end

	// forward path: stages 1..2 (divide estimate; correction and hue assembly)
	hsl_fwd u_fwd (.clk(clk), .en(en), .red(red_in), .green(green_in), .blue(blue_in),
		.hsl(hsl));
	// reverse path: gain, chroma, second component, channel build
	hsl_rev u_rev (.clk(clk), .en(en), .gain(gain_q), .hsl(hsl),
		.red(r), .green(g), .blue(b));

	always_ff @(posedge clk) begin
		if (en) begin
			red_out <= r; green_out <= g; blue_out <= b;
		end
	end
endmodule

// File: design/hsl_rdiv.sv
// Rounded quotient round(num*2^FracBits/den) with one register stage.
module hsl_rdiv (
	input  logic                   clk,
	input  logic                   en,
	input  logic [8:0]             num,
	input  logic [8:0]             den,
	output logic [hsl_pkg::FxW-1:0] quo
);
	import hsl_pkg::*;
	localparam int NW = FracBits + 10;
	logic [NW-1:0] n2_s1, q0_s1;
	logic [8:0] den_s1;
	logic [NW-1:0] n2;
	logic [RecW-1:0] rc;
	logic [NW+RecW-1:0] prod;
	logic [NW-1:0] q, rem;

	// doubled numerator plus divisor gives round-half-up after floor division
	assign n2 = (NW'(num) << (FracBits + 1)) + NW'(den);
	// divisors above 255 only ever take the value 510
	assign rc = den[8] ? Rec510 : RecTab[den[7:0]];
	assign prod = (NW+RecW)'(n2) * (NW+RecW)'(rc);

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s1 <= n2;
			den_s1 <= den;
			q0_s1 <= NW'(prod >> (FracBits + 11));
		end
	end

	// estimate may be off by one either way; correct against the exact remainder
	always_comb begin
		q = q0_s1;
		rem = n2_s1 - NW'(q * NW'({den_s1, 1'b0}));
		if (rem[NW-1]) q = q - NW'(1);
		else if (rem >= NW'({den_s1, 1'b0})) q = q + NW'(1);
	end

	assign quo = (den_s1 == 9'd0) ? '0 : FxW'(q);
endmodule

// File: design/hsl_fwd.sv
// RGB to HSL conversion, two stages.
module hsl_fwd (
	input  logic            clk,
	input  logic            en,
	input  hsl_pkg::chan_t  red,
	input  hsl_pkg::chan_t  green,
	input  hsl_pkg::chan_t  blue,
	output hsl_pkg::hsl_t   hsl
);
	import hsl_pkg::*;
	logic [7:0] mx, mn, dl, nm;
	logic [8:0] sm, dd;
	logic [2:0] base;
	logic neg;
	logic [FxW-1:0] lq, sq, hq;
	logic [FxW-1:0] lum_s2, sat_s2, hq_s2;
	logic [2:0] base_s1, base_s2;
	logic neg_s1, neg_s2, grey_s1, grey_s2;
	logic [FxW+2:0] hue;

	always_comb begin
		mx = red; if (green > mx) mx = green; if (blue > mx) mx = blue;
		mn = red; if (green < mn) mn = green; if (blue < mn) mn = blue;
		dl = mx - mn;
		sm = 9'(mx) + 9'(mn);
		dd = (sm >= 9'd255) ? 9'd510 - sm : sm;
		if (dd == 9'd0) dd = 9'd1;
		if (mx == red) begin
			base = 3'd0; neg = blue > green; nm = neg ? blue - green : green - blue;
		end else if (mx == green) begin
			base = 3'd2; neg = red > blue; nm = neg ? red - blue : blue - red;
		end else begin
			base = 3'd4; neg = green > red; nm = neg ? green - red : red - green;
		end
	end

	hsl_rdiv u_l (.clk(clk), .en(en), .num(sm), .den(9'd510), .quo(lq));
	hsl_rdiv u_s (.clk(clk), .en(en), .num(9'(dl)), .den(dd), .quo(sq));
	hsl_rdiv u_h (.clk(clk), .en(en), .num(9'(nm)), .den(9'(dl)), .quo(hq));

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= base; neg_s1 <= neg; grey_s1 <= (dl == 8'd0);
			lum_s2 <= lq;
			sat_s2 <= grey_s1 ? '0 : ((sq > FxOne) ? FxOne : sq);
			hq_s2 <= hq; base_s2 <= base_s1; neg_s2 <= neg_s1; grey_s2 <= grey_s1;
		end
	end

	always_comb begin
		hue = neg_s2 ? (FxW+3)'(base_s2 == 3'd0 ? 3'd6 : base_s2) * (FxW+3)'(FxOne)
			- (FxW+3)'(hq_s2)
			: (FxW+3)'(base_s2) * (FxW+3)'(FxOne) + (FxW+3)'(hq_s2);
		if (grey_s2 || hue >= (FxW+3)'(6) * (FxW+3)'(FxOne)) hue = '0;
		hsl.lum = lum_s2;
		hsl.sat = sat_s2;
		hsl.sector = 3'(hue >> FracBits);
		hsl.frac = FxW'(hue[FracBits-1:0]);
		hsl.grey = grey_s2;
	end
endmodule

// File: design/hsl_rev.sv
// Lightness gain and HSL to RGB conversion, three stages.
module hsl_rev (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [8:0]     gain,
	input  hsl_pkg::hsl_t         hsl,
	output hsl_pkg::chan_t        red,
	output hsl_pkg::chan_t        green,
	output hsl_pkg::chan_t        blue
);
	import hsl_pkg::*;
	localparam int PW = 2 * FxW + 2;
	localparam int TW = FxW + 3;
	hsl_t h_s1, h_s2;
	logic [FxW-1:0] lum_s1, lum_s2, c_s2, x_s3, c_s3, lum_s3;
	logic [2:0] sec_s3;
	logic signed [FxW+10:0] lg;
	logic [FxW-1:0] lc, t, w, c, x;
	logic [PW-1:0] pc, px;
	logic [TW-1:0] cr, cg, cb;

	function automatic chan_t to_ch(input logic [TW-1:0] tv);
		logic [TW+8:0] v;
		v = ((TW+9)'(tv) * (TW+9)'(255) + (TW+9)'(FxOne)) >> (FracBits + 1);
		return (v > (TW+9)'(255)) ? 8'd255 : 8'(v);
	endfunction

	always_comb begin
		lg = $signed({1'b0, hsl.lum}) * ($signed({gain[8], gain}) + 10'sd1);
		if (lg < 0) lc = '0;
		else if (lg > $signed((FxW+11)'(FxOne))) lc = FxOne;
		else lc = FxW'(lg);
	end

	always_comb begin
		t = (lum_s1 >= (FxOne >> 1)) ? FxW'(2) * (FxOne - lum_s1) : FxW'(2) * lum_s1;
		pc = PW'(t) * PW'(h_s1.sat) + PW'(FxOne >> 1);
		c = FxW'(pc >> FracBits);
		w = h_s2.sector[0] ? FxOne - h_s2.frac : h_s2.frac;
		px = PW'(c_s2) * PW'(w) + PW'(FxOne >> 1);
		x = FxW'(px >> FracBits);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= hsl; lum_s1 <= lc;
			h_s2 <= h_s1; lum_s2 <= lum_s1; c_s2 <= c;
			x_s3 <= x; c_s3 <= c_s2; lum_s3 <= lum_s2; sec_s3 <= h_s2.sector;
		end
	end

	// twice channel value is 2*ch + 2L - C, never negative
	always_comb begin
		logic [TW-1:0] base, tc, tx;
		base = TW'(lum_s3) * TW'(2) - TW'(c_s3);
		tc = base + TW'(c_s3) * TW'(2);
		tx = base + TW'(x_s3) * TW'(2);
		case (sec_s3)
			3'd0: begin cr = tc; cg = tx; cb = base; end
			3'd1: begin cr = tx; cg = tc; cb = base; end
			3'd2: begin cr = base; cg = tc; cb = tx; end
			3'd3: begin cr = base; cg = tx; cb = tc; end
			3'd4: begin cr = tx; cg = base; cb = tc; end
			default: begin cr = tc; cg = base; cb = tx; end
		endcase
		red = to_ch(cr);
		green = to_ch(cg);
		blue = to_ch(cb);
	end
endmodule

// File: tb/tb.sv
// Testbench for the HSL lightness gain pixel core: randomised pixels checked against an in-bench HSL model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsl_pkg::*;

	localparam longint One = longint'(1) << FracBits;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	chan_t red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	chan_t red_out, green_out, blue_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic signed [8:0] cfg_data = '0;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} pixel_t;

	pixel_t expected_pixels[$];
	int gain_k = 0;
	int fail_count = 0;
	bit sender_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	int hold_off_cycles = 0;

	hsl_lightness_gain_pixel_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("hsl_lightness_gain_pixel_core test failed");
		$finish;
	end

	function automatic longint rdiv(longint num, longint den);
		return (num + den / 2) / den;
	endfunction

	// twice-scaled channel value to 0..255, halves up
	function automatic chan_t to_chan(longint twice_val);
		longint v;
		if (twice_val <= 0) return '0;
		v = (twice_val * 255 + One) / (2 * One);
		if (v > 255) v = 255;
		return chan_t'(v);
	endfunction

	// RGB -> HSL, scale lightness by (1 + k), back to RGB
	function automatic pixel_t adjust_lightness(pixel_t p);
		longint r, g, b, mx, mn, delta, sum, d, lum, sat, hue, t, c, x, w, frac;
		longint cr, cg, cb;
		int sector;
		pixel_t q;
		r = p.r; g = p.g; b = p.b;
		mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
		mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
		delta = mx - mn;
		sum = mx + mn;
		lum = rdiv(sum * One, 510);
		hue = 0;
		sat = 0;
		if (delta != 0) begin
			d = 255 - ((sum >= 255) ? sum - 255 : 255 - sum);
			if (d < 1) d = 1;
			sat = rdiv(delta * One, d);
			if (sat > One) sat = One;
			if (mx == r) begin
				if (g >= b) hue = rdiv((g - b) * One, delta);
				else hue = 6 * One - rdiv((b - g) * One, delta);
			end else if (mx == g) begin
				if (b >= r) hue = 2 * One + rdiv((b - r) * One, delta);
				else hue = 2 * One - rdiv((r - b) * One, delta);
			end else begin
				if (r >= g) hue = 4 * One + rdiv((r - g) * One, delta);
				else hue = 4 * One - rdiv((g - r) * One, delta);
			end
			if (hue < 0 || hue >= 6 * One) hue = 0;
		end
		lum = lum * (1 + gain_k);
		if (lum > One) lum = One;
		if (lum < 0) lum = 0;
		t = 2 * lum - One;
		if (t < 0) t = -t;
		t = One - t;
		c = rdiv(t * sat, One);
		sector = int'(hue >> FracBits);
		frac = hue & (One - 1);
		w = (sector & 1) ? (One - frac) : frac;
		x = rdiv(c * w, One);
		case (sector)
			0: begin cr = c; cg = x; cb = 0; end
			1: begin cr = x; cg = c; cb = 0; end
			2: begin cr = 0; cg = c; cb = x; end
			3: begin cr = 0; cg = x; cb = c; end
			4: begin cr = x; cg = 0; cb = c; end
			default: begin cr = c; cg = 0; cb = x; end
		endcase
		q.r = to_chan(2 * cr + 2 * lum - c);
		q.g = to_chan(2 * cg + 2 * lum - c);
		q.b = to_chan(2 * cb + 2 * lum - c);
		return q;
	endfunction

	// Result checker; also drives out_stall in random bursts or a long hold-off.
	initial begin : result_checker
		pixel_t want;
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected item: %0d %0d %0d", red_out, green_out, blue_out);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (red_out !== want.r) begin
						$error("red_out expected %0d actual %0d", want.r, red_out);
						fail_count++;
					end
					if (green_out !== want.g) begin
						$error("green_out expected %0d actual %0d", want.g, green_out);
						fail_count++;
					end
					if (blue_out !== want.b) begin
						$error("blue_out expected %0d actual %0d", want.b, blue_out);
						fail_count++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one pixel, idling first at random, and wait for acceptance.
	task automatic send_pixel(chan_t r, chan_t g, chan_t b);
		pixel_t p;
		if (sender_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		p.r = r; p.g = g; p.b = b;
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (in_stall);
		expected_pixels.push_back(adjust_lightness(p));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Only written with the pipeline empty.
	task automatic write_gain(int k);
		cfg_valid <= 1'b1;
		cfg_data <= 9'(k);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_k = k;
	endtask

	task automatic send_random(int n);
		repeat (n) send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
	endtask

	task automatic test_directed_extremes();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);   // red max, blue above green: hue near full turn
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd170, 8'd85, 8'd85);
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd10, 8'd200, 8'd100);
		send_pixel(8'd90, 8'd20, 8'd240);
	endtask

	// Gain sweep incl. black (-1) and saturating white (255).
	task automatic test_gain_settings();
		int gains[7] = '{-1, 0, 1, 2, 255, -256 + 0, 7};
		foreach (gains[i]) begin
			drain_pipeline();
			if (gains[i] == -256) write_gain(-256);
			else write_gain(gains[i]);
			send_pixel(8'd255, 8'd0, 8'd0);
			send_pixel(8'd60, 8'd60, 8'd60);
			send_random(60);
		end
	endtask

	// Sink holds off long; pipeline fills and in_stall rises.
	task automatic test_backpressure();
		drain_pipeline();
		write_gain(1);
		hold_off_cycles = 60;
		send_random(40);
		drain_pipeline();   // sender pauses until all results are in
		send_random(40);
	endtask

	task automatic test_random_stream();
		send_random(500);
		drain_pipeline();
		write_gain(0);
		// last stretch: no idling anywhere
		sender_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		send_random(150);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_gain_settings();
		test_backpressure();
		test_random_stream();
		drain_pipeline();
		if (fail_count == 0)
			$display("hsl_lightness_gain_pixel_core test passed");
		else
			$display("hsl_lightness_gain_pixel_core test failed");
		$finish;
	end
endmodule
